### rtl/sips_pkg.sv
`default_nettype none

package sips_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int COUNT_W     = $clog2(TABLE_DEPTH + 1);
    localparam int POS_W       = 9;
    localparam int VALUE_W     = 32;
    localparam int ACTION_W    = 2;

    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_CMP,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

### rtl/sorted_insert_position_search.sv
// Sorted table with insert-position search. Clear and append words are taken while the
// block is idle; an append into a full table is dropped. A query runs a binary search over
// the single-port-read table RAM: each probe is an address issue, then a compare on the
// registered read data. An empty table skips the probes and returns 0. Results sit in an
// output register, so the next word may be taken while a result still waits.
`default_nettype none

module sorted_insert_position_search
    import sips_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic [ACTION_W-1:0]        i_action,
    input  wire logic signed [VALUE_W-1:0]  i_value,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic      [POS_W-1:0]           o_position
);

    t_state r_state;
    t_state n_state;

    logic [COUNT_W-1:0]        r_count;
    logic [COUNT_W-1:0]        r_lo;
    logic [COUNT_W-1:0]        r_hi;     // exclusive upper bound
    logic [COUNT_W-1:0]        r_mid;
    logic [POS_W-1:0]          r_res;
    logic signed [VALUE_W-1:0] r_target;
    logic                      r_out_valid;
    logic [POS_W-1:0]          r_position;

    logic               w_accept;
    logic               w_room;
    logic               w_ram_we;
    logic               w_ram_re;
    logic [VALUE_W-1:0] w_rdata;
    logic [COUNT_W:0]   w_sum;
    logic [COUNT_W-1:0] w_mid;
    logic [COUNT_W-1:0] w_mid_inc;
    logic               w_eq;
    logic               w_lt;
    logic               w_finish;
    logic               w_slot_free;

    assign w_accept    = i_in_valid && o_in_ready;
    assign w_room      = r_count < COUNT_W'(TABLE_DEPTH);
    assign w_slot_free = !r_out_valid || i_out_ready;

    assign w_sum     = {1'b0, r_lo} + {1'b0, r_hi} - {{COUNT_W{1'b0}}, 1'b1};
    assign w_mid     = w_sum[COUNT_W:1];
    assign w_mid_inc = r_mid + {{(COUNT_W-1){1'b0}}, 1'b1};

    assign w_eq     = $signed(w_rdata) == r_target;
    assign w_lt     = $signed(w_rdata) < r_target;
    assign w_finish = w_eq || (w_lt ? (w_mid_inc >= r_hi) : (r_lo >= r_mid));

    sips_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_count[ADDR_W-1:0]),
        .i_wdata (i_value),
        .i_re    (w_ram_re),
        .i_raddr (w_mid[ADDR_W-1:0]),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept && i_action == ACT_QUERY) begin
                    n_state = (r_count == '0) ? ST_DONE : ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                n_state = ST_CMP;
            end
            ST_CMP: begin
                n_state = w_finish ? ST_DONE : ST_ISSUE;
            end
            ST_DONE: begin
                if (w_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        w_ram_re   = 1'b0;
        w_ram_we   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                w_ram_we   = i_in_valid && i_action == ACT_APPEND && w_room;
            end
            ST_ISSUE: begin
                w_ram_re = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept && i_action == ACT_CLEAR) begin
                r_count <= '0;
            end else if (w_ram_we) begin
                r_count <= r_count + {{(COUNT_W-1){1'b0}}, 1'b1};
            end
            if (r_state == ST_DONE && w_slot_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && i_action == ACT_QUERY) begin
            r_target <= i_value;
            r_lo     <= '0;
            r_hi     <= r_count;
            r_res    <= '0;
        end
        if (r_state == ST_ISSUE) begin
            r_mid <= w_mid;
        end
        if (r_state == ST_CMP) begin
            if (w_lt) begin
                r_lo <= w_mid_inc;
            end else begin
                r_hi <= r_mid;
            end
            // greater or equal: this mid; less: one past it
            r_res <= (w_eq || !w_lt) ? POS_W'(r_mid) : POS_W'(w_mid_inc);
        end
        if (r_state == ST_DONE && w_slot_free) begin
            r_position <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_position  = r_position;

endmodule

`default_nettype wire

### rtl/sips_ram.sv
`default_nettype none

module sips_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### tb/insert_position_monitor.sv
`timescale 1ns / 100ps

module insert_position_monitor
    import sips_pkg::*;
(
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    input  wire logic                      i_in_ready,
    input  wire logic [ACTION_W-1:0]       i_action,
    input  wire logic signed [VALUE_W-1:0] i_value,
    input  wire logic                      i_out_valid,
    input  wire logic                      i_out_ready,
    input  wire logic [POS_W-1:0]          i_position,
    output int                             o_fail_count,
    output int                             o_pending
);

    logic signed [VALUE_W-1:0] stored_values [TABLE_DEPTH];
    int                        stored_count = 0;
    logic [POS_W-1:0]          expected_positions [$];

    function automatic logic [POS_W-1:0] insert_position(logic signed [VALUE_W-1:0] target);
        int lo;
        int hi;
        int mid;
        lo  = 0;
        hi  = stored_count - 1;
        mid = 0;
        if (stored_count == 0) begin
            return '0;
        end
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            if (stored_values[mid] == target) begin
                return POS_W'(mid);
            end
            if (stored_values[mid] < target) begin
                lo = mid + 1;
            end else begin
                hi = mid - 1;
            end
        end
        if (target < stored_values[mid]) begin
            return POS_W'(mid);
        end
        return POS_W'(mid + 1);
    endfunction

    always @(posedge i_clk) begin
        logic [POS_W-1:0] want;
        if (!i_rst_n) begin
            stored_count = 0;
        end else begin
            // result side first: a query taken at this edge cannot answer at it
            if (i_out_valid && i_out_ready) begin
                if (expected_positions.size() == 0) begin
                    $display("%0t: unexpected result word, expected none, got position %0d",
                             $time, i_position);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = expected_positions.pop_front();
                    if (i_position !== want) begin
                        $display("%0t: position mismatch, expected %0d, got %0d",
                                 $time, want, i_position);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                case (i_action)
                    ACT_CLEAR: begin
                        stored_count = 0;
                    end
                    ACT_APPEND: begin
                        if (stored_count < TABLE_DEPTH) begin
                            stored_values[stored_count] = i_value;
                            stored_count = stored_count + 1;
                        end
                    end
                    ACT_QUERY: begin
                        expected_positions.push_back(insert_position(i_value));
                    end
                    default: begin
                    end
                endcase
            end
        end
        o_pending = expected_positions.size();
    end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import sips_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;
    localparam int RANDOM_WORDS = 1900;
    localparam int SETTLE_CYCLES = 30;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic [ACTION_W-1:0]       action    = ACT_CLEAR;
    logic signed [VALUE_W-1:0] value     = '0;
    logic                      out_ready = 1'b0;
    wire logic                 in_ready;
    wire logic                 out_valid;
    wire logic [POS_W-1:0]     position;
    int                        fail_count;
    int                        pending;

    int idle_pct  = 0;
    int stall_pct = 0;
    int words_sent;
    int queries_sent;
    int ignored_sent;
    int full_loads;
    logic signed [VALUE_W-1:0] loaded [$];

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    sorted_insert_position_search dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_action    (action),
        .i_value     (value),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_position  (position)
    );

    insert_position_monitor monitor (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_action     (action),
        .i_value      (value),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_position   (position),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(negedge clk) begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    task automatic send_word(logic [ACTION_W-1:0] act, logic signed [VALUE_W-1:0] val);
        while ($urandom_range(0, 99) < idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        action   = act;
        value    = val;
        @(posedge clk);
        while (!in_ready) begin
            @(posedge clk);
        end
        @(negedge clk);
        case (act)
            ACT_CLEAR:  loaded.delete();
            ACT_APPEND: if (loaded.size() < TABLE_DEPTH) loaded.push_back(val);
            ACT_QUERY:  queries_sent++;
            default:    ignored_sent++;
        endcase
        if (act != ACT_UNUSED) begin
            words_sent++;
        end
    endtask

    task automatic drain();
        in_valid = 1'b0;
        while (pending != 0) begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_target();
        int k;
        k = $urandom_range(0, 9);
        if (loaded.size() == 0 || k < 3) begin
            return $urandom;
        end
        if (k < 6) begin
            return loaded[$urandom_range(0, loaded.size() - 1)];
        end
        if (k < 8) begin
            return loaded[$urandom_range(0, loaded.size() - 1)]
                   + ($urandom_range(0, 1) ? 32'sd1 : -32'sd1);
        end
        return (k == 8) ? VAL_MIN : VAL_MAX;
    endfunction

    task automatic load_sorted(int count, bit narrow);
        logic signed [VALUE_W-1:0] batch [$];
        logic signed [VALUE_W-1:0] base;
        base = $urandom;
        repeat (count) begin
            if ($urandom_range(0, 19) == 0) begin
                batch.push_back($urandom_range(0, 1) ? VAL_MIN : VAL_MAX);
            end else if (narrow) begin
                batch.push_back(base + $urandom_range(0, 15));
            end else begin
                batch.push_back($urandom);
            end
        end
        batch.sort();
        foreach (batch[i]) begin
            send_word(ACT_APPEND, batch[i]);
        end
    endtask

    task automatic set_phase(int phase);
        case (phase)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 70; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 70; end
            default: begin idle_pct = 30; stall_pct = 30; end
        endcase
    endtask

    initial begin
        int phase;
        int next_phase;
        int random_base;
        int depth;
        words_sent   = 0;
        queries_sent = 0;
        ignored_sent = 0;
        full_loads   = 0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: empty table, extremes, duplicates, unsorted tail, ignored action
        send_word(ACT_QUERY, 32'sd0);
        send_word(ACT_QUERY, VAL_MIN);
        send_word(ACT_CLEAR, 32'sd0);
        send_word(ACT_APPEND, VAL_MIN);
        send_word(ACT_QUERY, VAL_MIN);
        send_word(ACT_QUERY, VAL_MAX);
        send_word(ACT_APPEND, -32'sd1);
        send_word(ACT_APPEND, 32'sd0);
        send_word(ACT_APPEND, 32'sd0);
        send_word(ACT_APPEND, VAL_MAX);
        send_word(ACT_QUERY, 32'sd0);
        send_word(ACT_QUERY, -32'sd5);
        send_word(ACT_QUERY, 32'sd1);
        send_word(ACT_QUERY, VAL_MAX);
        send_word(ACT_QUERY, VAL_MIN);
        send_word(ACT_UNUSED, 32'shffff_ffff);
        send_word(ACT_QUERY, 32'sh7fff_fffe);
        send_word(ACT_APPEND, 32'sd5);
        send_word(ACT_QUERY, 32'sd5);
        send_word(ACT_CLEAR, 32'sd0);
        send_word(ACT_QUERY, 32'sd7);
        send_word(ACT_APPEND, 32'sd7);
        send_word(ACT_QUERY, 32'sd7);
        send_word(ACT_QUERY, 32'sd8);
        // sender holds off until every result is back
        drain();

        random_base = words_sent;
        phase = 0;
        set_phase(phase);
        while (words_sent - random_base < RANDOM_WORDS) begin
            next_phase = (words_sent - random_base) * 4 / RANDOM_WORDS;
            if (next_phase != phase) begin
                drain();
                phase = next_phase;
                set_phase(phase);
            end
            if ($urandom_range(0, 99) < 10) begin
                repeat ($urandom_range(5, 20)) begin
                    send_word(ACTION_W'($urandom_range(0, 3)), pick_target());
                end
            end else begin
                send_word(ACT_CLEAR, $urandom);
                if ($urandom_range(0, 11) == 0) begin
                    depth = TABLE_DEPTH;
                    full_loads++;
                end else begin
                    depth = $urandom_range(0, 24);
                end
                load_sorted(depth, $urandom_range(0, 2) == 0);
                if (depth == TABLE_DEPTH) begin
                    repeat ($urandom_range(1, 2)) send_word(ACT_APPEND, $urandom);
                end
                repeat ($urandom_range(2, 10)) send_word(ACT_QUERY, pick_target());
            end
        end
        drain();

        $display("run: %0d words sent, %0d of them queries, %0d ignored words",
                 words_sent, queries_sent, ignored_sent);
        $display("run: %0d full-table loads, empty and duplicate tables, four idle mixes",
                 full_loads);
        if (fail_count == 0 && pending == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule

### sorted_insert_position_search.f
rtl/sips_pkg.sv
rtl/sips_ram.sv
rtl/sorted_insert_position_search.sv
tb/insert_position_monitor.sv
tb/testbench.sv
